[rtl/csvft_pkg.sv]
// Shared types and constants of the CSV field tokenizer.
package csvft_pkg;

    localparam logic [7:0] QUOTE_BYTE   = 8'h22;
    localparam logic [7:0] NEWLINE_BYTE = 8'h0A;

    // Configuration register indexes.
    localparam logic CFG_DELIMITER = 1'b0;
    localparam logic CFG_MAX_ROW   = 1'b1;

    localparam logic [7:0]  DELIMITER_RESET = 8'd44;
    localparam logic [15:0] MAX_ROW_RESET   = 16'd4096;

    // Error codes as they appear on the result.
    localparam logic [1:0] ERR_NONE   = 2'd0;
    localparam logic [1:0] ERR_UNTERM = 2'd1;
    localparam logic [1:0] ERR_STRAY  = 2'd2;
    localparam logic [1:0] ERR_ROW    = 2'd3;

    typedef enum logic [2:0] {
        PH_START  = 3'd0,
        PH_UNQ    = 3'd1,
        PH_QUOTED = 3'd2,
        PH_QSEEN  = 3'd3,
        PH_DONE   = 3'd4,
        PH_ERR1   = 3'd5,
        PH_ERR2   = 3'd6,
        PH_ERR3   = 3'd7
    } t_phase;

    typedef enum logic [1:0] {
        TOK_BYTE   = 2'd0,
        TOK_DQUOTE = 2'd1,
        TOK_FIELD  = 2'd2,
        TOK_STATUS = 2'd3
    } t_tok_kind;

    // One queue entry: a token that expands into one or two result items.
    typedef struct packed {
        t_tok_kind   kind;
        logic [7:0]  data;
        logic [15:0] length;
        logic [15:0] index;
        logic        rec;
        logic [1:0]  err;
        logic        done;
    } t_token;

endpackage

[rtl/csv_field_tokenizer.sv]
// Each pushed token is stored in the queue and then loaded into the output register.
// Throughput: one input item per cycle while the queue is not full; a doubled quote gives two
// result items and the preceding held quote gives none, so a stream runs at one byte per cycle.
// A short token queue lets the input side run on while the output side stalls.
// Reset: i_rst_n is synchronous, active low; it clears the parser to field start,
// empties the queue and loads delimiter 44 and row limit 4096.
module csv_field_tokenizer #(
    parameter int COUNT_BITS  = 16,
    parameter int QUEUE_DEPTH = 4
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    // Configuration write port: register 0 delimiter, register 1 max_row_bytes.
    input  logic        i_cfg_we,
    input  logic        i_cfg_addr,
    input  logic [15:0] i_cfg_wdata,
    // Input item stream.
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [7:0]  s_tdata,   // [7:0] data_byte
    input  logic        s_tuser,   // [0] end_of_input
    // Result item stream.
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [39:0] m_tdata,   // [7:0] out_byte, [23:8] field_length, [39:24] field_index
    output logic [5:0]  m_tuser,   // [0] byte_valid, [1] field_end, [2] record_end,
                                   // [4:3] error_code, [5] done_res
    output logic        m_tlast    // last
);
    import csvft_pkg::*;

    // The front end classifies each accepted byte in the cycle it arrives and pushes
    // at most one token. An opening or held quote pushes nothing; a doubled quote
    // pushes a single token that the result stage turns into two quote items.
    logic   accept;
    logic   push;
    logic   full;
    logic   empty;
    logic   pop;
    t_token token;
    t_token head;

    assign s_tready = !full;
    assign accept   = s_tvalid && s_tready;

    csvft_front #(
        .COUNT_BITS (COUNT_BITS)
    ) u_front (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_cfg_we       (i_cfg_we),
        .i_cfg_addr     (i_cfg_addr),
        .i_cfg_wdata    (i_cfg_wdata),
        .i_accept       (accept),
        .i_data_byte    (s_tdata),
        .i_end_of_input (s_tuser),
        .o_push         (push),
        .o_token        (token)
    );

    // Tokens wait here while the output register is stalled.
    csvft_queue #(
        .QUEUE_DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (push),
        .i_token (token),
        .i_pop   (pop),
        .o_full  (full),
        .o_empty (empty),
        .o_head  (head)
    );

    // The result stage drains the queue into a registered output.
    csvft_back u_back (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_empty    (empty),
        .i_head     (head),
        .o_pop      (pop),
        .i_m_tready (m_tready),
        .o_m_tvalid (m_tvalid),
        .o_m_tdata  (m_tdata),
        .o_m_tuser  (m_tuser),
        .o_m_tlast  (m_tlast)
    );

endmodule

[rtl/csvft_front.sv]
// Front end: parse state, configuration registers and token classification.
module csvft_front #(
    parameter int COUNT_BITS = 16
) (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_cfg_we,
    input  logic                 i_cfg_addr,
    input  logic [15:0]          i_cfg_wdata,
    input  logic                 i_accept,
    input  logic [7:0]           i_data_byte,
    input  logic                 i_end_of_input,
    output logic                 o_push,
    output csvft_pkg::t_token    o_token
);
    import csvft_pkg::*;

    localparam int CMP_W  = (COUNT_BITS > 16) ? COUNT_BITS : 16;
    localparam int WIDE_W = COUNT_BITS + 16;
    localparam logic [COUNT_BITS-1:0] CNT_MAX = '1;

    typedef enum logic [3:0] {
        ACT_OPEN, ACT_HOLD, ACT_CONTENT, ACT_DQUOTE, ACT_FIELD, ACT_RECORD,
        ACT_DONE, ACT_ERR, ACT_REPEAT
    } t_action;

    logic [7:0]            r_delim;
    logic [15:0]           r_max_row;
    t_phase                r_phase, n_phase;
    logic [COUNT_BITS-1:0] r_fcnt, n_fcnt;
    logic [COUNT_BITS-1:0] r_row, n_row;
    logic [COUNT_BITS-1:0] r_pos, n_pos;

    t_action     act;
    logic [1:0]  act_err;
    logic        ends_rec;
    logic        row_over;
    logic        is_delim;
    logic        is_quote;
    logic [COUNT_BITS-1:0] fcnt_inc, fcnt_inc2, row_inc, pos_inc;
    logic [WIDE_W-1:0]     fcnt_wide, pos_wide;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_delim   <= DELIMITER_RESET;
            r_max_row <= MAX_ROW_RESET;
        end else if (i_cfg_we) begin
            if (i_cfg_addr == CFG_DELIMITER) begin
                r_delim <= i_cfg_wdata[7:0];
            end
            if (i_cfg_addr == CFG_MAX_ROW) begin
                r_max_row <= i_cfg_wdata;
            end
        end
    end

    assign is_quote = (i_data_byte == QUOTE_BYTE);
    assign is_delim = (i_data_byte == r_delim);
    assign ends_rec = (i_data_byte == NEWLINE_BYTE) && (r_phase != PH_QUOTED);
    assign row_over = !ends_rec && (CMP_W'(r_row) >= CMP_W'(r_max_row));

    assign fcnt_inc  = (r_fcnt == CNT_MAX) ? CNT_MAX : r_fcnt + 1'b1;
    assign fcnt_inc2 = (r_fcnt >= CNT_MAX - COUNT_BITS'(1)) ? CNT_MAX
                                                             : r_fcnt + COUNT_BITS'(2);
    assign row_inc   = (r_row == CNT_MAX) ? CNT_MAX : r_row + 1'b1;
    assign pos_inc   = (r_pos == CNT_MAX) ? CNT_MAX : r_pos + 1'b1;

    // Classify the offered byte against the current phase.
    always_comb begin
        act     = ACT_REPEAT;
        act_err = ERR_NONE;
        if (r_phase == PH_DONE) begin
            act = ACT_REPEAT;
        end else if (r_phase == PH_ERR1 || r_phase == PH_ERR2 || r_phase == PH_ERR3) begin
            act = ACT_REPEAT;
            act_err = (r_phase == PH_ERR1) ? ERR_UNTERM :
                      (r_phase == PH_ERR2) ? ERR_STRAY : ERR_ROW;
        end else if (i_end_of_input) begin
            if (r_phase == PH_START && r_pos == '0) begin
                act = ACT_DONE;
            end else begin
                act = ACT_ERR;
                act_err = (r_phase == PH_QUOTED) ? ERR_UNTERM : ERR_ROW;
            end
        end else if (row_over) begin
            act = ACT_ERR;
            act_err = ERR_ROW;
        end else begin
            unique case (r_phase)
                PH_START: begin
                    if (is_quote)      act = ACT_OPEN;
                    else if (ends_rec) act = ACT_RECORD;
                    else if (is_delim) act = ACT_FIELD;
                    else               act = ACT_CONTENT;
                end
                PH_UNQ: begin
                    if (ends_rec)      act = ACT_RECORD;
                    else if (is_delim) act = ACT_FIELD;
                    else               act = ACT_CONTENT;
                end
                PH_QUOTED: begin
                    if (is_quote) act = ACT_HOLD;
                    else          act = ACT_CONTENT;
                end
                PH_QSEEN: begin
                    if (is_quote)      act = ACT_DQUOTE;
                    else if (ends_rec) act = ACT_RECORD;
                    else if (is_delim) act = ACT_FIELD;
                    else begin
                        act = ACT_ERR;
                        act_err = ERR_STRAY;
                    end
                end
                default: act = ACT_REPEAT;
            endcase
        end
    end

    // Next state of the parser.
    always_comb begin
        n_phase = r_phase;
        n_fcnt  = r_fcnt;
        n_row   = r_row;
        n_pos   = r_pos;
        if (i_accept) begin
            if (act == ACT_OPEN || act == ACT_HOLD || act == ACT_CONTENT ||
                act == ACT_DQUOTE || act == ACT_FIELD) begin
                n_row = row_inc;
            end
            unique case (act)
                ACT_OPEN:    n_phase = PH_QUOTED;
                ACT_HOLD:    n_phase = PH_QSEEN;
                ACT_CONTENT: begin
                    n_fcnt = fcnt_inc;
                    if (r_phase == PH_START) n_phase = PH_UNQ;
                end
                ACT_DQUOTE: begin
                    n_fcnt  = fcnt_inc2;
                    n_phase = PH_QUOTED;
                end
                ACT_FIELD: begin
                    n_fcnt  = '0;
                    n_pos   = pos_inc;
                    n_phase = PH_START;
                end
                ACT_RECORD: begin
                    n_fcnt  = '0;
                    n_pos   = '0;
                    n_row   = '0;
                    n_phase = PH_START;
                end
                ACT_DONE: n_phase = PH_DONE;
                ACT_ERR: begin
                    n_phase = (act_err == ERR_UNTERM) ? PH_ERR1 :
                              (act_err == ERR_STRAY)  ? PH_ERR2 : PH_ERR3;
                end
                default: n_phase = r_phase;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase <= PH_START;
            r_fcnt  <= '0;
            r_row   <= '0;
            r_pos   <= '0;
        end else begin
            r_phase <= n_phase;
            r_fcnt  <= n_fcnt;
            r_row   <= n_row;
            r_pos   <= n_pos;
        end
    end

    assign fcnt_wide = WIDE_W'(r_fcnt);
    assign pos_wide  = WIDE_W'(r_pos);

    // Token for the queue.
    always_comb begin
        o_token        = '0;
        o_token.kind   = TOK_STATUS;
        o_push         = i_accept && (act != ACT_OPEN) && (act != ACT_HOLD);
        unique case (act)
            ACT_CONTENT: begin
                o_token.kind = TOK_BYTE;
                o_token.data = i_data_byte;
            end
            ACT_DQUOTE: o_token.kind = TOK_DQUOTE;
            ACT_FIELD, ACT_RECORD: begin
                o_token.kind   = TOK_FIELD;
                o_token.length = fcnt_wide[15:0];
                o_token.index  = pos_wide[15:0];
                o_token.rec    = (act == ACT_RECORD);
            end
            ACT_DONE: o_token.done = 1'b1;
            ACT_ERR:  o_token.err  = act_err;
            ACT_REPEAT: begin
                o_token.done = (r_phase == PH_DONE);
                o_token.err  = act_err;
            end
            default: o_token.kind = TOK_STATUS;
        endcase
    end

endmodule

[rtl/csvft_queue.sv]
// Short token queue between the front end and the result stage.
module csvft_queue #(
    parameter int QUEUE_DEPTH = 4
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_push,
    input  csvft_pkg::t_token i_token,
    input  logic              i_pop,
    output logic              o_full,
    output logic              o_empty,
    output csvft_pkg::t_token o_head
);
    import csvft_pkg::*;

    localparam int PTR_W = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
    localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);
    localparam logic [PTR_W-1:0] PTR_LAST = PTR_W'(QUEUE_DEPTH - 1);

    t_token            r_mem [QUEUE_DEPTH];
    logic [PTR_W-1:0]  r_wr_ptr, r_rd_ptr;
    logic [CNT_W-1:0]  r_count;
    logic              do_push, do_pop;

    assign o_full  = (r_count == CNT_W'(QUEUE_DEPTH));
    assign o_empty = (r_count == '0);
    assign o_head  = r_mem[r_rd_ptr];
    assign do_push = i_push && !o_full;
    assign do_pop  = i_pop && !o_empty;

    always_ff @(posedge i_clk) begin
        if (do_push) begin
            r_mem[r_wr_ptr] <= i_token;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            if (do_push) begin
                r_wr_ptr <= (r_wr_ptr == PTR_LAST) ? '0 : r_wr_ptr + 1'b1;
            end
            if (do_pop) begin
                r_rd_ptr <= (r_rd_ptr == PTR_LAST) ? '0 : r_rd_ptr + 1'b1;
            end
            if (do_push && !do_pop) begin
                r_count <= r_count + 1'b1;
            end else if (do_pop && !do_push) begin
                r_count <= r_count - 1'b1;
            end
        end
    end

endmodule

[rtl/csvft_back.sv]
// Result stage: expands tokens into result items held in an output register.
module csvft_back (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_empty,
    input  csvft_pkg::t_token i_head,
    output logic              o_pop,
    input  logic              i_m_tready,
    output logic              o_m_tvalid,
    output logic [39:0]       o_m_tdata,
    output logic [5:0]        o_m_tuser,
    output logic              o_m_tlast
);
    import csvft_pkg::*;

    logic        r_valid;
    logic        r_half;
    logic        load;
    logic        first_half;
    logic [7:0]  r_byte;
    logic        r_bval;
    logic        r_fend;
    logic [15:0] r_len;
    logic [15:0] r_idx;
    logic        r_rec;
    logic [1:0]  r_err;
    logic        r_done;
    logic        r_last;

    assign load       = !r_valid || i_m_tready;
    assign first_half = (i_head.kind == TOK_DQUOTE) && !r_half;
    assign o_pop      = load && !i_empty && !first_half;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
            r_half  <= 1'b0;
        end else if (load) begin
            r_valid <= !i_empty;
            if (!i_empty) begin
                r_half <= first_half;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (load && !i_empty) begin
            r_byte <= 8'd0;
            r_bval <= 1'b0;
            r_fend <= 1'b0;
            r_len  <= 16'd0;
            r_idx  <= 16'd0;
            r_rec  <= 1'b0;
            r_err  <= ERR_NONE;
            r_done <= 1'b0;
            r_last <= !first_half;
            unique case (i_head.kind)
                TOK_BYTE: begin
                    r_byte <= i_head.data;
                    r_bval <= 1'b1;
                end
                TOK_DQUOTE: begin
                    r_byte <= QUOTE_BYTE;
                    r_bval <= 1'b1;
                end
                TOK_FIELD: begin
                    r_fend <= 1'b1;
                    r_len  <= i_head.length;
                    r_idx  <= i_head.index;
                    r_rec  <= i_head.rec;
                end
                TOK_STATUS: begin
                    r_err  <= i_head.err;
                    r_done <= i_head.done;
                end
            endcase
        end
    end

    assign o_m_tvalid = r_valid;
    assign o_m_tdata  = {r_idx, r_len, r_byte};
    assign o_m_tuser  = {r_done, r_err, r_rec, r_fend, r_bval};
    assign o_m_tlast  = r_last;

endmodule

[rtl/csvft_checker.sv]
// Port-level checker for the CSV field tokenizer and its bind.
module csvft_checker (
    input logic        i_clk,
    input logic        i_rst_n,
    input logic        m_tvalid,
    input logic        m_tready,
    input logic [39:0] m_tdata,
    input logic [5:0]  m_tuser,
    input logic        m_tlast
);

    // A stalled result must not change.
    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tuser)
                                  && $stable(m_tlast))
        else $error("result changed while stalled");

    // A content byte and a field end never share one result.
    a_excl: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_tvalid |-> !(m_tuser[0] && m_tuser[1]))
        else $error("byte_valid and field_end together");

    // Record end only comes with a field end.
    a_rec: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_tvalid && m_tuser[2] |-> m_tuser[1])
        else $error("record_end without field_end");

    // Length and index are zero unless a field ends.
    a_len: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_tvalid && !m_tuser[1] |-> (m_tdata[39:8] == 32'd0))
        else $error("field length or index set outside a field end");

    // The first quote of a doubled pair is never the last result of its item.
    a_dq: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_tvalid && m_tready && !m_tlast |=> m_tvalid && m_tuser[0] && m_tlast)
        else $error("doubled quote not followed by its second byte");

endmodule

bind csv_field_tokenizer csvft_checker u_checker (
    .i_clk    (i_clk),
    .i_rst_n  (i_rst_n),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tuser  (m_tuser),
    .m_tlast  (m_tlast)
);

[tb/csv_field_tokenizer_tb.sv]
// Self-checking testbench for the CSV field tokenizer: a scoreboard predictor plus stream drivers.
package csvft_tb_pkg;

    import csvft_pkg::*;

    // One result item, with its fields in the order in which the scoreboard compares them.
    typedef struct packed {
        logic [7:0]  out_byte;
        logic        byte_valid;
        logic        field_end;
        logic [15:0] field_length;
        logic [15:0] field_index;
        logic        record_end;
        logic [1:0]  error_code;
        logic        done_res;
        logic        last;
    } csv_result_t;

    // Tracks the parser state and keeps the queue of predicted result items.
    class csv_scoreboard;
        logic [7:0]  delim;
        logic [15:0] row_limit;
        t_phase      phase;
        logic [15:0] field_len;
        logic [15:0] row_len;
        logic [15:0] field_pos;
        csv_result_t pending[$];
        int          errors;

        function new();
            delim     = DELIMITER_RESET;
            row_limit = MAX_ROW_RESET;
            phase     = PH_START;
            field_len = '0;
            row_len   = '0;
            field_pos = '0;
            errors    = 0;
        endfunction

        function void set_reg(logic addr, logic [15:0] value);
            if (addr == CFG_DELIMITER) begin
                delim = value[7:0];
            end else begin
                row_limit = value;
            end
        endfunction

        // Counters saturate instead of wrapping.
        function logic [15:0] bump(logic [15:0] v);
            return (v == 16'hFFFF) ? v : v + 16'd1;
        endfunction

        function void push_status(logic [1:0] err, logic done);
            csv_result_t r;
            r = '0;
            r.error_code = err;
            r.done_res = done;
            pending.push_back(r);
        endfunction

        function void stop(logic [1:0] err);
            case (err)
                ERR_UNTERM: phase = PH_ERR1;
                ERR_STRAY:  phase = PH_ERR2;
                default:    phase = PH_ERR3;
            endcase
            push_status(err, 1'b0);
        endfunction

        function void add_content(logic [7:0] b);
            csv_result_t r;
            r = '0;
            r.out_byte = b;
            r.byte_valid = 1'b1;
            pending.push_back(r);
            field_len = bump(field_len);
        endfunction

        function void close_field(logic rec);
            csv_result_t r;
            r = '0;
            r.field_end = 1'b1;
            r.field_length = field_len;
            r.field_index = field_pos;
            r.record_end = rec;
            pending.push_back(r);
            field_len = '0;
            if (rec) begin
                field_pos = '0;
                row_len = '0;
            end else begin
                field_pos = bump(field_pos);
            end
            phase = PH_START;
        endfunction

        // Predicts the result items of one accepted input item.
        function void note_item(logic [7:0] b, logic eoi);
            int          n_prior;
            logic        ends_rec;
            csv_result_t tail;
            n_prior = pending.size();
            case (phase)
                PH_DONE: push_status(ERR_NONE, 1'b1);
                PH_ERR1: push_status(ERR_UNTERM, 1'b0);
                PH_ERR2: push_status(ERR_STRAY, 1'b0);
                PH_ERR3: push_status(ERR_ROW, 1'b0);
                default: begin
                    if (eoi) begin
                        if (phase == PH_START && field_pos == 0) begin
                            phase = PH_DONE;
                            push_status(ERR_NONE, 1'b1);
                        end else begin
                            stop(phase == PH_QUOTED ? ERR_UNTERM : ERR_ROW);
                        end
                    end else begin
                        ends_rec = (b == NEWLINE_BYTE) && (phase != PH_QUOTED);
                        if (!ends_rec && row_len >= row_limit) begin
                            stop(ERR_ROW);
                        end else begin
                            if (!ends_rec) row_len = bump(row_len);
                            case (phase)
                                PH_START: begin
                                    if (b == QUOTE_BYTE) phase = PH_QUOTED;
                                    else if (ends_rec) close_field(1'b1);
                                    else if (b == delim) close_field(1'b0);
                                    else begin
                                        add_content(b);
                                        phase = PH_UNQ;
                                    end
                                end
                                PH_UNQ: begin
                                    if (ends_rec) close_field(1'b1);
                                    else if (b == delim) close_field(1'b0);
                                    else add_content(b);
                                end
                                PH_QUOTED: begin
                                    if (b == QUOTE_BYTE) phase = PH_QSEEN;
                                    else add_content(b);
                                end
                                default: begin
                                    // A held quote: the byte after it decides.
                                    if (b == QUOTE_BYTE) begin
                                        add_content(QUOTE_BYTE);
                                        add_content(QUOTE_BYTE);
                                        phase = PH_QUOTED;
                                    end else if (ends_rec) close_field(1'b1);
                                    else if (b == delim) close_field(1'b0);
                                    else stop(ERR_STRAY);
                                end
                            endcase
                        end
                    end
                end
            endcase
            if (pending.size() > n_prior) begin
                tail = pending.pop_back();
                tail.last = 1'b1;
                pending.push_back(tail);
            end
        endfunction

        function void compare(string field, int unsigned want, int unsigned got);
            if (want != got) begin
                $error("%s: expected %0d, got %0d", field, want, got);
                errors++;
            end
        endfunction

        function void check_result(csv_result_t got);
            csv_result_t want;
            if (pending.size() == 0) begin
                $error("result item with nothing expected: %h", got);
                errors++;
                return;
            end
            want = pending.pop_front();
            compare("out_byte", want.out_byte, got.out_byte);
            compare("byte_valid", want.byte_valid, got.byte_valid);
            compare("field_end", want.field_end, got.field_end);
            compare("field_length", want.field_length, got.field_length);
            compare("field_index", want.field_index, got.field_index);
            compare("record_end", want.record_end, got.record_end);
            compare("error_code", want.error_code, got.error_code);
            compare("done_res", want.done_res, got.done_res);
            compare("last", want.last, got.last);
        endfunction
    endclass

endpackage

module csv_field_tokenizer_tb;

    import csvft_pkg::*;
    import csvft_tb_pkg::*;

    // The watchdog ends the run once its count of cycles without any accepted item passes this limit.
    localparam int QUIET_LIMIT = 3000;
    // Length of the long receiver hold-off that fills the token queue.
    localparam int HOLD_CYCLES = 120;
    // Cycles allowed after the last expected result for a late or stray one.
    localparam int TAIL_CYCLES = 8;
    // Fewest items per random phase; a phase ends only after a whole record.
    localparam int PHASE_ITEMS = 110;
    localparam int N_PHASES = 7;

    // Ways the text stream can end. Errors are sticky and reset happens only
    // once, so each run picks one of them at random for its final part.
    localparam int END_CLEAN  = 0;
    localparam int END_UNTERM = 1;
    localparam int END_STRAY  = 2;
    localparam int END_LONG   = 3;
    localparam int END_OPEN   = 4;

    logic        i_clk = 1'b0;
    logic        i_rst_n = 1'b0;
    logic        i_cfg_we = 1'b0;
    logic        i_cfg_addr = 1'b0;
    logic [15:0] i_cfg_wdata = '0;
    logic        s_tvalid = 1'b0;
    logic        s_tready;
    logic [7:0]  s_tdata = '0;   // [7:0] data_byte
    logic        s_tuser = 1'b0; // [0] end_of_input
    logic        m_tvalid;
    logic        m_tready = 1'b0;
    logic [39:0] m_tdata;        // [7:0] out_byte, [23:8] field_length, [39:24] field_index
    logic [5:0]  m_tuser;        // [0] byte_valid, [1] field_end, [2] record_end,
                                 // [4:3] error_code, [5] done_res
    logic        m_tlast;

    csv_scoreboard sb;
    csv_result_t   seen_item;

    int tx_idle_pct = 16;
    int rx_idle_pct = 62;
    int hold_asked = 0;
    int hold_served = 0;
    int hold_left = 0;
    int quiet = 0;
    int items_sent = 0;

    csv_field_tokenizer dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_addr  (i_cfg_addr),
        .i_cfg_wdata (i_cfg_wdata),
        .s_tvalid    (s_tvalid),
        .s_tready    (s_tready),
        .s_tdata     (s_tdata),
        .s_tuser     (s_tuser),
        .m_tvalid    (m_tvalid),
        .m_tready    (m_tready),
        .m_tdata     (m_tdata),
        .m_tuser     (m_tuser),
        .m_tlast     (m_tlast)
    );

    always begin
        #2 i_clk = 1'b1;
        #2 i_clk = 1'b0;
    end

    // Unpack the master side into the field order of the scoreboard.
    assign seen_item = {m_tdata[7:0], m_tuser[0], m_tuser[1], m_tdata[23:8],
                        m_tdata[39:24], m_tuser[2], m_tuser[4:3], m_tuser[5], m_tlast};

    // Receiver: checks every accepted result item and decides tready for the
    // next cycle. A hold-off request from the stimulus keeps tready low for a
    // long stretch, counted here, while the sender keeps offering items.
    always @(posedge i_clk) begin
        if (i_rst_n && m_tvalid && m_tready) begin
            sb.check_result(seen_item);
        end
        if (hold_left > 0) begin
            hold_left = hold_left - 1;
            m_tready <= 1'b0;
        end else if (hold_served != hold_asked) begin
            hold_served = hold_asked;
            hold_left = HOLD_CYCLES;
            m_tready <= 1'b0;
        end else begin
            m_tready <= ($urandom_range(99) >= rx_idle_pct);
        end
    end

    // Watchdog: a run with no accepted item on either side for too long fails.
    always @(posedge i_clk) begin
        if ((s_tvalid && s_tready) || (m_tvalid && m_tready)) begin
            quiet <= 0;
        end else if (quiet == QUIET_LIMIT) begin
            $display("** csv_field_tokenizer: FAILED **");
            $finish;
        end else begin
            quiet <= quiet + 1;
        end
    end

    // Offers one item, with random idle cycles in front, and waits until the
    // block takes it. tvalid stays high after acceptance so that back-to-back
    // items need no extra assignment in the same step.
    task automatic send_item(input logic [7:0] b, input logic eoi);
        while ($urandom_range(99) < tx_idle_pct) begin
            s_tvalid <= 1'b0;
            @(posedge i_clk);
        end
        s_tvalid <= 1'b1;
        s_tdata <= b;
        s_tuser <= eoi;
        do @(posedge i_clk); while (!s_tready);
        sb.note_item(b, eoi);
        items_sent++;
    endtask

    // Stops offering items and waits until every predicted result has come,
    // then a few more cycles so that a held quote or a stray result shows up.
    task automatic drain();
        s_tvalid <= 1'b0;
        do @(posedge i_clk); while (sb.pending.size() != 0);
        repeat (TAIL_CYCLES) @(posedge i_clk);
    endtask

    // Writes both registers back to back; called only while the block is idle.
    task automatic write_config(input logic [7:0] d, input logic [15:0] limit);
        i_cfg_we <= 1'b1;
        i_cfg_addr <= CFG_DELIMITER;
        i_cfg_wdata <= {8'h00, d};
        @(posedge i_clk);
        i_cfg_addr <= CFG_MAX_ROW;
        i_cfg_wdata <= limit;
        @(posedge i_clk);
        i_cfg_we <= 1'b0;
        sb.set_reg(CFG_DELIMITER, {8'h00, d});
        sb.set_reg(CFG_MAX_ROW, limit);
    endtask

    // Content bytes lean toward the bytes the parser treats specially.
    function automatic logic [7:0] pick_byte(input logic [7:0] d);
        case ($urandom_range(9))
            0:       return QUOTE_BYTE;
            1:       return NEWLINE_BYTE;
            2:       return d;
            default: return 8'($urandom_range(255));
        endcase
    endfunction

    // Sends one well-formed record that fits the row limit. Quoted fields may
    // hold the delimiter, newlines and doubled quotes; unquoted fields may
    // hold quotes anywhere but at their start. With the quote as delimiter
    // only non-empty unquoted fields are legal, since a quote at field start
    // or after a closing quote would not separate fields.
    task automatic send_record(input logic [7:0] d, input int limit);
        logic [7:0] line[$];
        logic [7:0] fld[$];
        logic [7:0] c;
        int         n_fields;
        int         len;
        int         used;
        int         cost;
        bit         quoted;
        n_fields = $urandom_range(1, 4);
        used = 0;
        for (int f = 0; f < n_fields; f++) begin
            fld.delete();
            quoted = (d != QUOTE_BYTE) && ($urandom_range(2) == 0);
            len = ($urandom_range(15) == 0) ? $urandom_range(6, 30) : $urandom_range(0, 5);
            if (d == QUOTE_BYTE && len == 0) len = 1;
            if (quoted) fld.push_back(QUOTE_BYTE);
            for (int k = 0; k < len; k++) begin
                c = pick_byte(d);
                if (quoted) begin
                    fld.push_back(c);
                    if (c == QUOTE_BYTE) fld.push_back(c);
                end else begin
                    while (c == d || c == NEWLINE_BYTE || (k == 0 && c == QUOTE_BYTE))
                        c = pick_byte(d);
                    fld.push_back(c);
                end
            end
            if (quoted) fld.push_back(QUOTE_BYTE);
            // Every byte but the closing newline counts toward the row limit.
            cost = fld.size() + ((f > 0) ? 1 : 0);
            if (used + cost > limit) break;
            if (f > 0) line.push_back(d);
            foreach (fld[j]) line.push_back(fld[j]);
            used += cost;
        end
        line.push_back(NEWLINE_BYTE);
        foreach (line[j]) send_item(line[j], 1'b0);
    endtask

    initial begin
        // Directed text under the reset settings: extreme bytes and a quote in
        // an unquoted field; a quoted field holding a newline, the delimiter
        // and a doubled quote; an empty record; an empty field, an empty
        // quoted field and an empty last field.
        logic [7:0] warmup [18] = '{8'h00, 8'hFF, QUOTE_BYTE, DELIMITER_RESET,
                                    QUOTE_BYTE, 8'h78, NEWLINE_BYTE, DELIMITER_RESET,
                                    QUOTE_BYTE, QUOTE_BYTE, QUOTE_BYTE, NEWLINE_BYTE,
                                    NEWLINE_BYTE, DELIMITER_RESET, QUOTE_BYTE, QUOTE_BYTE,
                                    DELIMITER_RESET, NEWLINE_BYTE};
        // Settings per random phase: the reset values, both delimiter
        // extremes with the largest row limit and a limit of one, newline and quote
        // as the delimiter, a random pair and a tab with a tight limit.
        logic [7:0]  delims [N_PHASES] = '{DELIMITER_RESET, 8'h00, 8'hFF, NEWLINE_BYTE,
                                           QUOTE_BYTE, 8'h00, 8'h09};
        logic [15:0] limits [N_PHASES] = '{MAX_ROW_RESET, 16'hFFFF, 16'd1, 16'd40,
                                           16'd200, 16'd0, 16'd12};
        logic [7:0]  d;
        logic [15:0] limit;
        int          mark;
        int          end_kind;

        sb = new();
        repeat (12) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        foreach (warmup[k]) send_item(warmup[k], 1'b0);
        drain();

        for (int p = 0; p < N_PHASES; p++) begin
            d = delims[p];
            limit = limits[p];
            if (p == 5) begin
                d = 8'($urandom_range(255));
                limit = 16'($urandom_range(2, 100));
            end
            // Sender idles lightly and receiver heavily first, then the
            // other way round, then neither side idles.
            if (p < 3) begin
                tx_idle_pct = 16;
                rx_idle_pct <= 62;
            end else if (p < 5) begin
                tx_idle_pct = 62;
                rx_idle_pct <= 16;
            end else begin
                tx_idle_pct = 0;
                rx_idle_pct <= 0;
            end
            write_config(d, limit);
            if (p == 1 || p == 5) hold_asked <= hold_asked + 1;
            mark = items_sent;
            while (items_sent - mark < PHASE_ITEMS) send_record(d, limit);
            drain();
        end

        // Final part: a few records, then one way of ending the stream, then
        // more items to show that the final status sticks.
        end_kind = $urandom_range(END_OPEN);
        limit = (end_kind == END_LONG) ? 16'($urandom_range(1, 6)) : MAX_ROW_RESET;
        write_config(DELIMITER_RESET, limit);
        repeat (4) send_record(DELIMITER_RESET, limit);
        case (end_kind)
            END_CLEAN: begin
                send_item(8'($urandom_range(255)), 1'b1);
            end
            END_UNTERM: begin
                send_item(QUOTE_BYTE, 1'b0);
                send_item(8'h61, 1'b0);
                send_item(8'($urandom_range(255)), 1'b1);
            end
            END_STRAY: begin
                send_item(QUOTE_BYTE, 1'b0);
                send_item(8'h61, 1'b0);
                send_item(QUOTE_BYTE, 1'b0);
                send_item(8'h62, 1'b0);
            end
            END_LONG: begin
                // One byte past the limit stops the parse.
                repeat (int'(limit) + 1) send_item(8'h61, 1'b0);
            end
            default: begin
                // End of input right after a delimiter, inside an open record.
                send_item(8'h61, 1'b0);
                send_item(DELIMITER_RESET, 1'b0);
                send_item(8'($urandom_range(255)), 1'b1);
            end
        endcase
        repeat (6) send_item(8'($urandom_range(255)), 1'($urandom_range(1)));
        drain();

        if (sb.errors == 0) begin
            $display("** csv_field_tokenizer: PASSED **");
        end else begin
            $display("** csv_field_tokenizer: FAILED **");
        end
        $finish;
    end

endmodule

[files.f]
rtl/csvft_pkg.sv
rtl/csvft_front.sv
rtl/csvft_queue.sv
rtl/csvft_back.sv
rtl/csv_field_tokenizer.sv
rtl/csvft_checker.sv
tb/csv_field_tokenizer_tb.sv
